/* rtl/tpga_pkg.sv */
package tpga_pkg;

  // Default geometry
  localparam int COORD_BITS_DEF     = 10;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  // Field widths
  localparam int GAIN_W     = 24;
  localparam int THRESH_W   = 8;
  localparam int SPEED_W    = 8;
  localparam int ERR_OUT_W  = 11;
  localparam int CTRL_W     = 16;
  localparam int ACC_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Integral clamp is +-50.0 in Q.8, control output clamp
  localparam int ACC_LIMIT  = 12800;
  localparam int CTRL_LIMIT = 32767;

  // Register reset values
  localparam logic [GAIN_W-1:0]   GAIN_P_X_RST    = 24'd72090;
  localparam logic [GAIN_W-1:0]   GAIN_I_X_RST    = 24'd7;
  localparam logic [GAIN_W-1:0]   GAIN_D_X_RST    = 24'd1638400;
  localparam logic [GAIN_W-1:0]   GAIN_P_Y_RST    = 24'd58982;
  localparam logic [GAIN_W-1:0]   GAIN_I_Y_RST    = 24'd0;
  localparam logic [GAIN_W-1:0]   GAIN_D_Y_RST    = 24'd983040;
  localparam logic [THRESH_W-1:0] DEAD_BAND_RST   = 8'd3;
  localparam logic [THRESH_W-1:0] SPEED_LIMIT_RST = 8'd30;

  // Integral decay: X keeps 4/5, Y keeps 9/10, truncated toward zero.
  // n/den is done as (n * RECIP) >> SH, low by at most one, then corrected.
  localparam int DECAY_NUM_X = 4;
  localparam int DECAY_DEN_X = 5;
  localparam int DECAY_NUM_Y = 9;
  localparam int DECAY_DEN_Y = 10;
  localparam int RECIP_X     = 52428;   // floor(2^18 / 5)
  localparam int RECIP_SH_X  = 18;
  localparam int RECIP_Y     = 104857;  // floor(2^20 / 10)
  localparam int RECIP_SH_Y  = 20;
  localparam int DEC_N_W     = 17;      // |accum| * num
  localparam int DEC_Q_W     = 15;      // decayed magnitude

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P_X    = 3'd0,
    REG_GAIN_I_X    = 3'd1,
    REG_GAIN_D_X    = 3'd2,
    REG_GAIN_P_Y    = 3'd3,
    REG_GAIN_I_Y    = 3'd4,
    REG_GAIN_D_Y    = 3'd5,
    REG_DEAD_BAND   = 3'd6,
    REG_SPEED_LIMIT = 3'd7
  } tpga_reg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_MUL_P,
    OP_MUL_D,
    OP_MUL_R,
    OP_UPDATE,
    OP_MUL_I,
    OP_ADD_I,
    OP_ROUND,
    OP_WRITE
  } tpga_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_R,
    ST_UPDATE,
    ST_MUL_I,
    ST_ADD_I,
    ST_ROUND,
    ST_DONE
  } tpga_state_t;

  typedef struct packed {
    tpga_op_t op;
  } tpga_cmd_t;

endpackage

/* rtl/tpga_sample_if.sv */
interface tpga_sample_if #(
  parameter int COORD_BITS = tpga_pkg::COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic                  target_seen;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [COORD_BITS-1:0] aim_x;
  logic [COORD_BITS-1:0] aim_y;

  modport source (
    output valid, mode, target_seen, pos_x, pos_y, aim_x, aim_y,
    input  ready
  );
  modport sink (
    input  valid, mode, target_seen, pos_x, pos_y, aim_x, aim_y,
    output ready
  );
endinterface

/* rtl/tpga_result_if.sv */
interface tpga_result_if ();
  logic                                   valid;
  logic                                   ready;
  logic [tpga_pkg::SPEED_W-1:0]           speed_x;
  logic                                   dir_x;
  logic [tpga_pkg::SPEED_W-1:0]           speed_y;
  logic                                   dir_y;
  logic signed [tpga_pkg::ERR_OUT_W-1:0]  err_x_out;
  logic signed [tpga_pkg::ERR_OUT_W-1:0]  err_y_out;
  logic signed [tpga_pkg::CTRL_W-1:0]     ctrl_x_out;
  logic signed [tpga_pkg::CTRL_W-1:0]     ctrl_y_out;

  modport source (
    output valid, speed_x, dir_x, speed_y, dir_y, err_x_out, err_y_out,
           ctrl_x_out, ctrl_y_out,
    input  ready
  );
  modport sink (
    input  valid, speed_x, dir_x, speed_y, dir_y, err_x_out, err_y_out,
           ctrl_x_out, ctrl_y_out,
    output ready
  );
endinterface

/* rtl/tpga_cfg_if.sv */
interface tpga_cfg_if ();
  logic                            valid;
  logic                            ready;
  logic [tpga_pkg::CFG_IDX_W-1:0]  index;
  logic [tpga_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/tpga_axis.sv */
module tpga_axis #(
  parameter int COORD_BITS     = tpga_pkg::COORD_BITS_DEF,
  parameter int GAIN_FRAC_BITS = tpga_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tpga_pkg::tpga_cmd_t                 cmd,
  input  logic                                is_y,
  input  logic signed [COORD_BITS:0]          err_in,
  input  logic [tpga_pkg::GAIN_W-1:0]         kp,
  input  logic [tpga_pkg::GAIN_W-1:0]         ki,
  input  logic [tpga_pkg::GAIN_W-1:0]         kd,
  input  logic [tpga_pkg::THRESH_W-1:0]       dead_band,
  input  logic [tpga_pkg::THRESH_W-1:0]       speed_limit,
  output logic signed [COORD_BITS:0]          err,
  output logic [tpga_pkg::SPEED_W-1:0]        speed,
  output logic                                dir,
  output logic signed [tpga_pkg::CTRL_W-1:0]  ctrl
);

  localparam int ERR_W   = COORD_BITS + 1;
  localparam int DIF_W   = COORD_BITS + 2;
  localparam int ACS_W   = ERR_W + 9;
  localparam int MA_W    = tpga_pkg::GAIN_W + 1;
  localparam int MB_W    = (DIF_W > tpga_pkg::DEC_N_W + 1) ? DIF_W : tpga_pkg::DEC_N_W + 1;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int SUM_W   = PROD_W + 10;
  localparam int SH      = GAIN_FRAC_BITS + 8;
  localparam int WHOLE_W = SUM_W - SH;
  localparam int ACC_W   = tpga_pkg::ACC_W;
  localparam int NQ_W    = tpga_pkg::DEC_N_W;
  localparam int Q_W     = tpga_pkg::DEC_Q_W;

  localparam logic signed [ACS_W-1:0]   ACS_HI   = ACS_W'(tpga_pkg::ACC_LIMIT);
  localparam logic signed [ACS_W-1:0]   ACS_LO   = ACS_W'(-tpga_pkg::ACC_LIMIT);
  localparam logic signed [WHOLE_W-1:0] WHOLE_HI = WHOLE_W'(tpga_pkg::CTRL_LIMIT);
  localparam logic signed [WHOLE_W-1:0] WHOLE_LO = WHOLE_W'(-tpga_pkg::CTRL_LIMIT);

  logic signed [ERR_W-1:0]   prev;
  logic signed [ACC_W-1:0]   accum;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   sum;
  logic signed [WHOLE_W-1:0] whole;
  logic                      sum_pos;

  logic signed [DIF_W-1:0]   diff;
  logic [ERR_W-1:0]          err_mag;
  logic                      above;
  logic                      below;
  logic [ACC_W-2:0]          acc_mag;
  logic [NQ_W-1:0]           dec_n;
  logic [Q_W-1:0]            q0;
  logic [NQ_W-1:0]           dec_back;
  logic [NQ_W-1:0]           dec_rem;
  logic [NQ_W-1:0]           dec_den;
  logic [Q_W-1:0]            q;
  logic signed [ACC_W-1:0]   acc_dec;
  logic signed [ACS_W-1:0]   acc_add;
  logic signed [ACC_W-1:0]   acc_clamp;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic                      round_up;
  logic [WHOLE_W-1:0]        whole_mag;

  assign diff    = DIF_W'(err) - DIF_W'(prev);
  assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign above   = err_mag > ERR_W'(dead_band);
  assign below   = err_mag < ERR_W'(dead_band);

  // decay: |accum| * num / den with reciprocal estimate plus one fix-up
  assign acc_mag  = (ACC_W-1)'(accum[ACC_W-1] ? -accum : accum);
  assign dec_n    = is_y ? NQ_W'(acc_mag) * NQ_W'(tpga_pkg::DECAY_NUM_Y)
                         : NQ_W'(acc_mag) * NQ_W'(tpga_pkg::DECAY_NUM_X);
  assign q0       = is_y ? prod[tpga_pkg::RECIP_SH_Y +: Q_W]
                         : prod[tpga_pkg::RECIP_SH_X +: Q_W];
  assign dec_den  = is_y ? NQ_W'(tpga_pkg::DECAY_DEN_Y) : NQ_W'(tpga_pkg::DECAY_DEN_X);
  assign dec_back = is_y ? NQ_W'(q0) * NQ_W'(tpga_pkg::DECAY_DEN_Y)
                         : NQ_W'(q0) * NQ_W'(tpga_pkg::DECAY_DEN_X);
  assign dec_rem  = dec_n - dec_back;
  assign q        = q0 + Q_W'(dec_rem >= dec_den);
  assign acc_dec  = accum[ACC_W-1] ? -ACC_W'(q) : ACC_W'(q);

  // accumulate e in Q.8 with anti-windup clamp
  assign acc_add   = ACS_W'(accum) + (ACS_W'(err) <<< 8);
  assign acc_clamp = (acc_add > ACS_HI) ? ACC_W'(tpga_pkg::ACC_LIMIT) :
                     (acc_add < ACS_LO) ? ACC_W'(-tpga_pkg::ACC_LIMIT) :
                     ACC_W'(acc_add);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      tpga_pkg::OP_MUL_P: begin
        mul_a = MA_W'(kp);
        mul_b = MB_W'(err);
      end
      tpga_pkg::OP_MUL_D: begin
        mul_a = MA_W'(kd);
        mul_b = MB_W'(diff);
      end
      tpga_pkg::OP_MUL_R: begin
        mul_a = is_y ? MA_W'(tpga_pkg::RECIP_Y) : MA_W'(tpga_pkg::RECIP_X);
        mul_b = MB_W'(dec_n);
      end
      tpga_pkg::OP_MUL_I: begin
        mul_a = MA_W'(ki);
        mul_b = MB_W'(accum);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign round_up = sum[SUM_W-1] && (sum[SH-1:0] != '0);

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.op)
      tpga_pkg::OP_LOAD:  err <= err_in;
      tpga_pkg::OP_MUL_D: sum <= SUM_W'(prod) <<< 8;
      tpga_pkg::OP_MUL_R: sum <= sum + (SUM_W'(prod) <<< 8);
      tpga_pkg::OP_ADD_I: sum <= sum + SUM_W'(prod);
      tpga_pkg::OP_ROUND: begin
        whole   <= WHOLE_W'(sum >>> SH) + WHOLE_W'(round_up);
        sum_pos <= !sum[SUM_W-1] && (sum != '0);
      end
      default: ;
    endcase
  end

  // loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      accum <= '0;
      prev  <= '0;
    end else begin
      case (cmd.op)
        tpga_pkg::OP_CLEAR: begin
          accum <= '0;
          prev  <= '0;
        end
        tpga_pkg::OP_UPDATE: begin
          accum <= above ? acc_clamp : acc_dec;
          prev  <= err;
        end
        default: ;
      endcase
    end
  end

  assign whole_mag = whole[WHOLE_W-1] ? WHOLE_W'(-whole) : WHOLE_W'(whole);

  assign ctrl  = (whole > WHOLE_HI) ? tpga_pkg::CTRL_W'(tpga_pkg::CTRL_LIMIT) :
                 (whole < WHOLE_LO) ? tpga_pkg::CTRL_W'(-tpga_pkg::CTRL_LIMIT) :
                 whole[tpga_pkg::CTRL_W-1:0];
  assign speed = below ? '0 :
                 (whole_mag > WHOLE_W'(speed_limit)) ? speed_limit :
                 whole_mag[tpga_pkg::SPEED_W-1:0];
  assign dir   = below ? 1'b0 : (is_y ? sum_pos : !sum_pos);

endmodule

/* rtl/tpga_dp.sv */
module tpga_dp #(
  parameter int COORD_BITS     = tpga_pkg::COORD_BITS_DEF,
  parameter int GAIN_FRAC_BITS = tpga_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  tpga_pkg::tpga_cmd_t                    cmd,
  input  logic [COORD_BITS-1:0]                  pos_x,
  input  logic [COORD_BITS-1:0]                  pos_y,
  input  logic [COORD_BITS-1:0]                  aim_x,
  input  logic [COORD_BITS-1:0]                  aim_y,
  input  logic                                   cfg_valid,
  input  logic [tpga_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tpga_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic [tpga_pkg::SPEED_W-1:0]           speed_x,
  output logic                                   dir_x,
  output logic [tpga_pkg::SPEED_W-1:0]           speed_y,
  output logic                                   dir_y,
  output logic signed [tpga_pkg::ERR_OUT_W-1:0]  err_x_out,
  output logic signed [tpga_pkg::ERR_OUT_W-1:0]  err_y_out,
  output logic signed [tpga_pkg::CTRL_W-1:0]     ctrl_x_out,
  output logic signed [tpga_pkg::CTRL_W-1:0]     ctrl_y_out
);

  logic [tpga_pkg::GAIN_W-1:0]   gain_p_x;
  logic [tpga_pkg::GAIN_W-1:0]   gain_i_x;
  logic [tpga_pkg::GAIN_W-1:0]   gain_d_x;
  logic [tpga_pkg::GAIN_W-1:0]   gain_p_y;
  logic [tpga_pkg::GAIN_W-1:0]   gain_i_y;
  logic [tpga_pkg::GAIN_W-1:0]   gain_d_y;
  logic [tpga_pkg::THRESH_W-1:0] dead_band;
  logic [tpga_pkg::THRESH_W-1:0] speed_limit;

  logic signed [COORD_BITS:0]          ex_in;
  logic signed [COORD_BITS:0]          ey_in;
  logic signed [COORD_BITS:0]          ex;
  logic signed [COORD_BITS:0]          ey;
  logic [tpga_pkg::SPEED_W-1:0]        spd_x;
  logic [tpga_pkg::SPEED_W-1:0]        spd_y;
  logic                                dx;
  logic                                dy;
  logic signed [tpga_pkg::CTRL_W-1:0]  cx;
  logic signed [tpga_pkg::CTRL_W-1:0]  cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p_x    <= tpga_pkg::GAIN_P_X_RST;
      gain_i_x    <= tpga_pkg::GAIN_I_X_RST;
      gain_d_x    <= tpga_pkg::GAIN_D_X_RST;
      gain_p_y    <= tpga_pkg::GAIN_P_Y_RST;
      gain_i_y    <= tpga_pkg::GAIN_I_Y_RST;
      gain_d_y    <= tpga_pkg::GAIN_D_Y_RST;
      dead_band   <= tpga_pkg::DEAD_BAND_RST;
      speed_limit <= tpga_pkg::SPEED_LIMIT_RST;
    end else if (cfg_valid) begin
      case (tpga_pkg::tpga_reg_t'(cfg_index))
        tpga_pkg::REG_GAIN_P_X:    gain_p_x    <= cfg_data[tpga_pkg::GAIN_W-1:0];
        tpga_pkg::REG_GAIN_I_X:    gain_i_x    <= cfg_data[tpga_pkg::GAIN_W-1:0];
        tpga_pkg::REG_GAIN_D_X:    gain_d_x    <= cfg_data[tpga_pkg::GAIN_W-1:0];
        tpga_pkg::REG_GAIN_P_Y:    gain_p_y    <= cfg_data[tpga_pkg::GAIN_W-1:0];
        tpga_pkg::REG_GAIN_I_Y:    gain_i_y    <= cfg_data[tpga_pkg::GAIN_W-1:0];
        tpga_pkg::REG_GAIN_D_Y:    gain_d_y    <= cfg_data[tpga_pkg::GAIN_W-1:0];
        tpga_pkg::REG_DEAD_BAND:   dead_band   <= cfg_data[tpga_pkg::THRESH_W-1:0];
        tpga_pkg::REG_SPEED_LIMIT: speed_limit <= cfg_data[tpga_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // error = aim - measured
  assign ex_in = $signed({1'b0, aim_x}) - $signed({1'b0, pos_x});
  assign ey_in = $signed({1'b0, aim_y}) - $signed({1'b0, pos_y});

  tpga_axis #(
    .COORD_BITS     (COORD_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_axis_x (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .is_y        (1'b0),
    .err_in      (ex_in),
    .kp          (gain_p_x),
    .ki          (gain_i_x),
    .kd          (gain_d_x),
    .dead_band   (dead_band),
    .speed_limit (speed_limit),
    .err         (ex),
    .speed       (spd_x),
    .dir         (dx),
    .ctrl        (cx)
  );

  tpga_axis #(
    .COORD_BITS     (COORD_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_axis_y (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .is_y        (1'b1),
    .err_in      (ey_in),
    .kp          (gain_p_y),
    .ki          (gain_i_y),
    .kd          (gain_d_y),
    .dead_band   (dead_band),
    .speed_limit (speed_limit),
    .err         (ey),
    .speed       (spd_y),
    .dir         (dy),
    .ctrl        (cy)
  );

  // result register, loaded only once the previous result has gone
  always_ff @(posedge clk) begin
    if (cmd.op == tpga_pkg::OP_WRITE) begin
      speed_x    <= spd_x;
      dir_x      <= dx;
      speed_y    <= spd_y;
      dir_y      <= dy;
      err_x_out  <= tpga_pkg::ERR_OUT_W'(ex);
      err_y_out  <= tpga_pkg::ERR_OUT_W'(ey);
      ctrl_x_out <= cx;
      ctrl_y_out <= cy;
    end
  end

endmodule

/* rtl/tpga_ctrl.sv */
module tpga_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  input  logic                mode,
  input  logic                target_seen,
  input  logic                result_ready,
  output logic                sample_ready,
  output logic                result_valid,
  output tpga_pkg::tpga_cmd_t cmd
);

  tpga_pkg::tpga_state_t state;
  tpga_pkg::tpga_state_t state_next;
  logic                  out_free;

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpga_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tpga_pkg::ST_IDLE: begin
        if (sample_valid && !mode && target_seen) begin
          state_next = tpga_pkg::ST_MUL_P;
        end
      end
      tpga_pkg::ST_MUL_P:  state_next = tpga_pkg::ST_MUL_D;
      tpga_pkg::ST_MUL_D:  state_next = tpga_pkg::ST_MUL_R;
      tpga_pkg::ST_MUL_R:  state_next = tpga_pkg::ST_UPDATE;
      tpga_pkg::ST_UPDATE: state_next = tpga_pkg::ST_MUL_I;
      tpga_pkg::ST_MUL_I:  state_next = tpga_pkg::ST_ADD_I;
      tpga_pkg::ST_ADD_I:  state_next = tpga_pkg::ST_ROUND;
      tpga_pkg::ST_ROUND:  state_next = tpga_pkg::ST_DONE;
      tpga_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = tpga_pkg::ST_IDLE;
        end
      end
      default: state_next = tpga_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sample_ready = 1'b0;
    cmd.op       = tpga_pkg::OP_NONE;
    case (state)
      tpga_pkg::ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          if (mode) begin
            cmd.op = tpga_pkg::OP_CLEAR;
          end else if (target_seen) begin
            cmd.op = tpga_pkg::OP_LOAD;
          end
        end
      end
      tpga_pkg::ST_MUL_P:  cmd.op = tpga_pkg::OP_MUL_P;
      tpga_pkg::ST_MUL_D:  cmd.op = tpga_pkg::OP_MUL_D;
      tpga_pkg::ST_MUL_R:  cmd.op = tpga_pkg::OP_MUL_R;
      tpga_pkg::ST_UPDATE: cmd.op = tpga_pkg::OP_UPDATE;
      tpga_pkg::ST_MUL_I:  cmd.op = tpga_pkg::OP_MUL_I;
      tpga_pkg::ST_ADD_I:  cmd.op = tpga_pkg::OP_ADD_I;
      tpga_pkg::ST_ROUND:  cmd.op = tpga_pkg::OP_ROUND;
      tpga_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.op = tpga_pkg::OP_WRITE;
        end
      end
      default: cmd.op = tpga_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.op == tpga_pkg::OP_WRITE) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

/* rtl/two_axis_pid_gimbal_aim_top.sv */
// An accepted tracking sample steps through MUL_P to ROUND; WRITE then loads the result,
//   waiting while an earlier result is still held in the result register.
// No new sample is taken until after WRITE; clear and no-target samples leave the port open.
// Each axis lane has a single 25x18 multiplier, used 4 times per tracking sample.
// Reset (rst, synchronous, active high) zeroes integrals and last errors and
//   reloads the default gains, dead band and speed limit.
module two_axis_pid_gimbal_aim_top #(
  parameter int COORD_BITS     = tpga_pkg::COORD_BITS_DEF,
  parameter int GAIN_FRAC_BITS = tpga_pkg::GAIN_FRAC_BITS_DEF
) (
  input logic           clk,
  input logic           rst,
  tpga_sample_if.sink   sample,
  tpga_result_if.source result,
  tpga_cfg_if.sink      cfg
);

  // Controller and datapath talk only through this command bundle. The
  // controller steps both axis lanes in lock step:
  //   LOAD   latch aim - pos for each axis
  //   MUL_P  kp * e
  //   MUL_D  kd * (e - last e), P term lands in the sum
  //   MUL_R  reciprocal multiply for the integral decay, D term lands
  //   UPDATE integral accumulate/clamp or decay, last e <= e
  //   MUL_I  ki * integral
  //   ADD_I  I term lands
  //   ROUND  truncate the Q(frac+8) sum toward zero
  //   WRITE  saturate and load the result register
  tpga_pkg::tpga_cmd_t cmd;

  // Config writes are always taken; the user must issue them only while idle (unenforced).
  assign cfg.ready = 1'b1;

  tpga_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample.valid),
    .mode         (sample.mode),
    .target_seen  (sample.target_seen),
    .result_ready (result.ready),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .cmd          (cmd)
  );

  // Datapath: config registers, the two axis lanes and the result register.
  // The result register holds a finished transaction while the lanes go on
  // with the next sample; WRITE waits only if that transaction is still unread.
  tpga_dp #(
    .COORD_BITS     (COORD_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .pos_x      (sample.pos_x),
    .pos_y      (sample.pos_y),
    .aim_x      (sample.aim_x),
    .aim_y      (sample.aim_y),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .speed_x    (result.speed_x),
    .dir_x      (result.dir_x),
    .speed_y    (result.speed_y),
    .dir_y      (result.dir_y),
    .err_x_out  (result.err_x_out),
    .err_y_out  (result.err_y_out),
    .ctrl_x_out (result.ctrl_x_out),
    .ctrl_y_out (result.ctrl_y_out)
  );

endmodule

/* rtl/tpga_checker.sv */
module tpga_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_valid,
  input logic                               s_ready,
  input logic                               s_mode,
  input logic                               s_seen,
  input logic                               r_valid,
  input logic                               r_ready,
  input logic [tpga_pkg::SPEED_W-1:0]       r_speed_x,
  input logic [tpga_pkg::CTRL_W-1:0]        r_ctrl_x
);

  // a tracking sample occupies the lanes, so the port closes right after it
  a_busy_after_track: assert property (@(posedge clk) disable iff (rst)
    (s_valid && s_ready && !s_mode && s_seen) |=> !s_ready)
    else $error("sample port open right after a tracking sample");

  // clear and no-target samples leave the port open for the next sample
  a_quick_no_result: assert property (@(posedge clk) disable iff (rst)
    (s_valid && s_ready && (s_mode || !s_seen)) |=> s_ready)
    else $error("clear or no-target sample held the port");

  // a new result only appears at the end of a tracking sample's work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(r_valid) |-> $past(!s_ready))
    else $error("result raised while the block was idle");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (r_valid && !r_ready) |=> (r_valid && $stable(r_speed_x) && $stable(r_ctrl_x)))
    else $error("stalled result changed");

endmodule

bind two_axis_pid_gimbal_aim_top tpga_checker u_tpga_checker (
  .clk       (clk),
  .rst       (rst),
  .s_valid   (sample.valid),
  .s_ready   (sample.ready),
  .s_mode    (sample.mode),
  .s_seen    (sample.target_seen),
  .r_valid   (result.valid),
  .r_ready   (result.ready),
  .r_speed_x (result.speed_x),
  .r_ctrl_x  (result.ctrl_x_out)
);
